@@ rtl/alte_pkg.sv @@
// Shared types and constants for the array list table engine.
package alte_pkg;

    localparam int CMD_W      = 3;
    localparam int POS_W      = 8;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 9;
    localparam int CAP_W      = 9;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_READ   = 3'd3,
        CMD_WRITE  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

endpackage

@@ rtl/alte_if.sv @@
// Request, response and configuration channel interfaces.
interface alte_req_if
    import alte_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;

    modport source (output valid, output cmd, output position, output word_in, input ready);
    modport sink   (input valid, input cmd, input position, input word_in, output ready);
endinterface

interface alte_rsp_if
    import alte_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] word_out;
    logic [POS_W-1:0]         found_at;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] total;

    modport source (output valid, output status, output word_out, output found_at,
                    output count, output total, input ready);
    modport sink   (input valid, input status, input word_out, input found_at,
                    input count, input total, output ready);
endinterface

interface alte_cfg_if
    import alte_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

@@ rtl/array_list_table_engine.sv @@
// Array list table engine: sequencer, list state and configuration.
//
// Usage:
//   req carries one item: cmd (insert, delete, search, read, write),
//   position and word_in. It is taken when req.valid and req.ready are high.
//   rsp returns one item per request: status, word_out, found_at, count and
//   total. cfg writes the capacity register; it is always ready.
//   req.ready is high only while the engine is idle; one item is in work at
//   a time, and the next is taken only after its result has been delivered.
// Sequence:
//   rejected requests, unused cmd codes and an empty search go from decode
//   straight to the result; read fetches one entry, insert at end places one,
//   and write reads the old entry, then places the new one. Insert, delete and
//   search walk the list one entry per cycle; a search stops at the first match.
// Reset:
//   count and total clear to zero, capacity goes to 256. The entry RAM is
//   not cleared; only written entries are ever read.
// Stall:
//   the result is held in registers while rsp.ready is low, and no new
//   request is taken until it has been delivered.
module array_list_table_engine
    import alte_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    alte_req_if.sink    req,
    alte_rsp_if.source  rsp,
    alte_cfg_if.sink    cfg
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_WALK   = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_FETCH  = 7'b0010000,
        S_PLACE  = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] total_reg, total_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         end_reg, end_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    status_t               status_reg, status_next;
    logic [WORD_W-1:0]     wout_reg, wout_next;
    logic [POS_W-1:0]      found_reg, found_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    alu_op_t               alu_op;
    logic [DATA_WIDTH-1:0] alu_operand;
    logic [DATA_WIDTH-1:0] alu_sum;
    logic                  alu_match;

    logic [WW-1:0]         pos_x;
    logic [WW-1:0]         count_x;
    logic [WW-1:0]         cap_x;
    logic [WW-1:0]         limit_x;
    logic [AW-1:0]         pos_a;
    logic [AW-1:0]         last_a;

    alte_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    alte_alu #(
        .WIDTH (DATA_WIDTH)
    ) u_alu (
        .op      (alu_op),
        .acc     (total_reg),
        .operand (alu_operand),
        .key     (key_reg),
        .sum     (alu_sum),
        .match   (alu_match)
    );

    assign pos_x   = WW'(pos_reg);
    assign count_x = WW'(count_reg);
    assign cap_x   = WW'(cap_reg);
    assign limit_x = (cap_x < WW'(DEPTH)) ? cap_x : WW'(DEPTH);
    assign pos_a   = AW'(pos_reg);
    assign last_a  = AW'(count_reg - 1'b1);

    // shared unit: add the key when placing, subtract read data otherwise
    assign alu_op      = (state_reg == S_PLACE) ? ALU_ADD : ALU_SUB;
    assign alu_operand = (state_reg == S_PLACE) ? key_reg : ram_rdata;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        status_next    = status_reg;
        wout_next      = wout_reg;
        found_next     = found_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_a;
        ram_wdata      = key_reg;
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = cmd_t'(req.cmd);
                    pos_next   = req.position;
                    key_next   = DATA_WIDTH'(req.word_in);
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = ST_OK;
                wout_next   = '0;
                found_next  = '0;
                state_next  = S_OUT;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (pos_x > count_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (count_x >= limit_x)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (pos_x == count_x)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            ptr_next   = last_a;
                            end_next   = pos_a;
                            state_next = S_WALK;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (pos_x >= count_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            ptr_next   = pos_a;
                            end_next   = last_a;
                            state_next = S_WALK;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        status_next = ST_NOT_FOUND;
                        if (count_reg != '0)
                        begin
                            ptr_next   = '0;
                            end_next   = last_a;
                            state_next = S_WALK;
                        end
                    end
                    CMD_READ:
                    begin
                        if (pos_x >= count_x)
                        begin
                            status_next = ST_RANGE;
                            wout_next   = '1;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = pos_a;
                            state_next = S_FETCH;
                        end
                    end
                    CMD_WRITE:
                    begin
                        if (pos_x >= count_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = pos_a;
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_WALK, S_DRAIN:
            begin
                // issue the next read while the walk is still open
                if (state_reg == S_WALK)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = ptr_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    if (ptr_reg == end_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                    else if (cmd_reg == CMD_INSERT)
                    begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                else
                begin
                    case (cmd_reg)
                        CMD_INSERT: state_next = S_PLACE;
                        CMD_DELETE:
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = S_OUT;
                        end
                        default:    state_next = S_OUT;
                    endcase
                end

                // retire the entry read in the previous cycle
                if (pend_reg)
                begin
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pend_addr_reg + 1'b1;
                            ram_wdata = ram_rdata;
                        end
                        CMD_DELETE:
                        begin
                            if (pend_addr_reg == pos_a)
                            begin
                                total_next = alu_sum;
                                wout_next  = WORD_W'(ram_rdata);
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pend_addr_reg - 1'b1;
                                ram_wdata = ram_rdata;
                            end
                        end
                        default:
                        begin
                            if (alu_match)
                            begin
                                status_next = ST_OK;
                                found_next  = POS_W'(pend_addr_reg);
                                pend_next   = 1'b0;
                                state_next  = S_OUT;
                            end
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    wout_next  = WORD_W'(ram_rdata);
                    state_next = S_OUT;
                end
                else
                begin
                    total_next = alu_sum;
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_a;
                ram_wdata  = key_reg;
                total_next = alu_sum;
                if (cmd_reg == CMD_INSERT)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            cap_reg   <= CAP_RESET;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        wout_reg      <= wout_next;
        found_reg     <= found_next;
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign rsp.valid    = (state_reg == S_OUT);
    assign rsp.status   = status_reg;
    assign rsp.word_out = wout_reg;
    assign rsp.found_at = found_reg;
    assign rsp.count    = COUNT_W'(count_reg);
    assign rsp.total    = WORD_W'(total_reg);

endmodule

@@ rtl/alte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module alte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/alte_alu.sv @@
// Shared accumulate and key compare unit.
module alte_alu
    import alte_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  alu_op_t          op,
    input  logic [WIDTH-1:0] acc,
    input  logic [WIDTH-1:0] operand,
    input  logic [WIDTH-1:0] key,
    output logic [WIDTH-1:0] sum,
    output logic             match
);

    always_comb
    begin
        unique case (op)
            ALU_ADD: sum = acc + operand;
            ALU_SUB: sum = acc - operand;
            default: sum = acc;
        endcase
    end

    assign match = (operand == key);

endmodule

@@ tb/array_list_table_engine_tb.sv @@
// Testbench for the array list table engine: directed and random list requests checked against a model.
module array_list_table_engine_tb
    import alte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int MAX_GAP         = 6;
    localparam int MAX_PRINTS      = 40;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word_in;
    } list_request_t;

    typedef struct packed {
        status_t                  status;
        logic signed [WORD_W-1:0] word_out;
        logic [POS_W-1:0]         found_at;
        logic [COUNT_W-1:0]       count;
        logic signed [WORD_W-1:0] total;
    } list_result_t;

    logic clk;
    logic rst_n;

    alte_req_if req_ch();
    alte_rsp_if rsp_ch();
    alte_cfg_if cfg_ch();

    array_list_table_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // list model state
    logic signed [WORD_W-1:0] list_words [DEPTH_DEF];
    int                       list_len = 0;
    logic signed [WORD_W-1:0] list_sum = '0;
    logic [CAP_W-1:0]         list_cap = CAP_RESET;

    list_request_t request_q [$];
    list_result_t  pending_results [$];

    int   items_pushed = 0;
    int   items_taken  = 0;
    int   results_seen = 0;
    int   error_count  = 0;
    int   cycle_count  = 0;
    int   req_gap      = 0;
    int   rsp_gap      = 0;
    bit   req_offer    = 1'b0;
    bit   req_fire     = 1'b0;
    bit   rsp_fire     = 1'b0;
    bit   rsp_hold     = 1'b0;
    bit   no_idle      = 1'b0;
    event rsp_stall_ev;

    list_request_t taken_rq;
    list_request_t next_rq;
    list_result_t  got_rsp;
    list_result_t  want_rsp;

    function automatic list_result_t list_engine_step(input list_request_t rq);
        list_result_t r;
        int           eff_cap;
        int           p;
        int           i;
        r        = '0;
        r.status = ST_OK;
        p        = int'(rq.position);
        eff_cap  = (list_cap < DEPTH_DEF) ? int'(list_cap) : DEPTH_DEF;
        case (rq.cmd)
            CMD_INSERT:
            begin
                if (p > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= eff_cap)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = rq.word_in;
                    list_len++;
                    list_sum = list_sum + rq.word_in;
                end
            end
            CMD_DELETE:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    r.word_out = list_words[p];
                    for (i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    list_sum = list_sum - r.word_out;
                end
            end
            CMD_SEARCH:
            begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < list_len; i++)
                begin
                    if (list_words[i] == rq.word_in)
                    begin
                        r.status   = ST_OK;
                        r.found_at = POS_W'(i);
                        break;
                    end
                end
            end
            CMD_READ:
            begin
                if (p >= list_len)
                begin
                    r.status   = ST_RANGE;
                    r.word_out = '1;
                end
                else
                    r.word_out = list_words[p];
            end
            CMD_WRITE:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    list_sum      = list_sum - list_words[p] + rq.word_in;
                    list_words[p] = rq.word_in;
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(list_len);
        r.total = list_sum;
        return r;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(MAX_GAP);
    endfunction

    function automatic logic signed [WORD_W-1:0] draw_word();
        case ($urandom_range(7)) inside
            0: return {1'b1, {(WORD_W-1){1'b0}}};
            1: return {1'b0, {(WORD_W-1){1'b1}}};
            2, 3: return WORD_W'($urandom_range(4)) - 2;
            default: return $urandom;
        endcase
    endfunction

    function automatic list_request_t draw_request(input int ins_pct);
        list_request_t rq;
        int            r;
        rq.word_in  = draw_word();
        rq.position = POS_W'($urandom_range(255));
        r           = $urandom_range(99);
        if (r < ins_pct)
        begin
            rq.cmd = CMD_INSERT;
            if ($urandom_range(9) != 0)
                rq.position = POS_W'($urandom_range(list_len > 255 ? 255 : list_len));
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 30)
                rq.cmd = CMD_DELETE;
            else if (r < 55)
                rq.cmd = CMD_SEARCH;
            else if (r < 75)
                rq.cmd = CMD_READ;
            else if (r < 95)
                rq.cmd = CMD_WRITE;
            else
                rq.cmd = CMD_W'($urandom_range(int'(CMD_WRITE) + 1, (1 << CMD_W) - 1));
            if (list_len > 0 && $urandom_range(9) != 0)
                rq.position = POS_W'($urandom_range(list_len - 1));
            if (rq.cmd == CMD_SEARCH && list_len > 0 && $urandom_range(9) < 6)
                rq.word_in = list_words[$urandom_range(list_len - 1)];
        end
        return rq;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    task automatic push_request(input list_request_t rq);
        request_q.push_back(rq);
        items_pushed++;
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] position,
                        input logic signed [WORD_W-1:0] word_in);
        list_request_t rq;
        rq.cmd      = cmd;
        rq.position = position;
        rq.word_in  = word_in;
        push_request(rq);
    endtask

    task automatic settle();
        while (items_taken != items_pushed || pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_ch.capacity <= value;
        cfg_ch.valid    <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        list_cap = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stall_at: receiver holds off; pause_at: sender waits for all results
    task automatic run_random(input int n_items, input int ins_pct, input int stall_at,
                              input int pause_at);
        int k;
        for (k = 0; k < n_items; k++)
        begin
            wait (items_taken == items_pushed);
            if (k == stall_at)
                -> rsp_stall_ev;
            if (k == pause_at)
                while (pending_results.size() != 0)
                    @(posedge clk);
            push_request(draw_request(ins_pct));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // request side: accept, predict
    always @(posedge clk)
    begin
        req_fire <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            taken_rq.cmd      = req_ch.cmd;
            taken_rq.position = req_ch.position;
            taken_rq.word_in  = req_ch.word_in;
            pending_results.push_back(list_engine_step(taken_rq));
            items_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_offer || req_fire)
        begin
            if (req_offer)
            begin
                req_offer = 1'b0;
                req_gap   = draw_gap();
            end
            if (req_gap > 0 || request_q.size() == 0)
            begin
                if (req_gap > 0)
                    req_gap--;
                req_ch.valid <= 1'b0;
            end
            else
            begin
                next_rq = request_q.pop_front();
                req_ch.cmd      <= next_rq.cmd;
                req_ch.position <= next_rq.position;
                req_ch.word_in  <= next_rq.word_in;
                req_ch.valid    <= 1'b1;
                req_offer = 1'b1;
            end
        end
    end

    // response side: compare against oldest prediction
    always @(posedge clk)
    begin
        rsp_fire <= rst_n && rsp_ch.valid && rsp_ch.ready;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_rsp.status   = status_t'(rsp_ch.status);
            got_rsp.word_out = rsp_ch.word_out;
            got_rsp.found_at = rsp_ch.found_at;
            got_rsp.count    = rsp_ch.count;
            got_rsp.total    = rsp_ch.total;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none pending", results_seen));
            else
            begin
                want_rsp = pending_results.pop_front();
                check_field("status", WORD_W'(rsp_ch.status), WORD_W'(want_rsp.status));
                check_field("word_out", got_rsp.word_out, want_rsp.word_out);
                check_field("found_at", WORD_W'(got_rsp.found_at), WORD_W'(want_rsp.found_at));
                check_field("count", WORD_W'(got_rsp.count), WORD_W'(want_rsp.count));
                check_field("total", got_rsp.total, want_rsp.total);
            end
            results_seen++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_fire)
                rsp_gap = draw_gap();
            if (rsp_hold)
                rsp_ch.ready <= 1'b0;
            else if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always
    begin
        @(rsp_stall_ev);
        rsp_hold = 1'b1;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
    end

    initial
    begin
        int c;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_INSERT;
        req_ch.position = '0;
        req_ch.word_in  = '0;
        rsp_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = CAP_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list
        send(CMD_READ, 0, 0);
        send(CMD_DELETE, 0, 0);
        send(CMD_WRITE, 0, 1);
        send(CMD_SEARCH, 0, 0);
        send(CMD_INSERT, 1, 5);
        // build with extremes, duplicate zero
        send(CMD_INSERT, 0, 32'sh7fff_ffff);
        send(CMD_INSERT, 0, 32'sh8000_0000);
        send(CMD_INSERT, 2, -1);
        send(CMD_INSERT, 1, 0);
        send(CMD_INSERT, 0, 0);
        send(CMD_SEARCH, 0, 0);
        send(CMD_SEARCH, 0, -1);
        send(CMD_SEARCH, 0, 32'sh1234_5678);
        send(CMD_READ, 4, 0);
        send(CMD_READ, 5, 0);
        send(CMD_WRITE, 0, 32'sh5555_5555);
        send(CMD_WRITE, 5, 7);
        send(CMD_DELETE, 255, 0);
        send(CMD_DELETE, 1, 0);
        send(CMD_DELETE, 3, 0);
        for (c = int'(CMD_WRITE) + 1; c < (1 << CMD_W); c++)
            send(CMD_W'(c), 0, 0);
        send(CMD_INSERT, 255, 9);

        // capacity below count, position test before full test
        write_capacity(2);
        send(CMD_INSERT, 0, 11);
        send(CMD_INSERT, 200, 12);
        send(CMD_DELETE, 0, 0);
        send(CMD_INSERT, 0, 13);
        send(CMD_DELETE, 0, 0);
        send(CMD_INSERT, 1, 14);
        write_capacity(0);
        send(CMD_INSERT, 0, 15);

        write_capacity(16);
        run_random(70, 40, -1, 30);
        write_capacity(1);
        run_random(40, 40, -1, -1);
        write_capacity(0);
        run_random(15, 60, -1, -1);
        write_capacity(9'd511);
        run_random(320, 90, 40, 200);
        write_capacity(100);
        run_random(50, 10, -1, -1);
        write_capacity(CAP_RESET);
        no_idle = 1'b1;
        run_random(40, 50, -1, -1);

        wait (items_taken == items_pushed);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH_DEF + 16) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
